FILE: src/mcssl_pkg.sv
// shared types, codes and constants for the servo slew limiter
package mcssl_pkg;

   // field widths
   localparam int POS_W   = 15;
   localparam int TGT_W   = 16;
   localparam int STEP_W  = 15;
   localparam int ACT_W   = 4;
   localparam int PULSE_W = 12;
   localparam int CH_FLD_W = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 15;

   // full travel in hundredths of a degree
   localparam logic [POS_W-1:0] FULL_SCALE = POS_W'(18000);

   // most results a tick can give
   localparam int RESULT_CAP = 8;

   // width of the product of position and pulse span
   localparam int PROD_W = POS_W + PULSE_W;

   // request codes
   localparam logic [1:0] REQ_SET_TARGET = 2'd0;
   localparam logic [1:0] REQ_ADD_TARGET = 2'd1;
   localparam logic [1:0] REQ_DIRECT_POS = 2'd2;
   localparam logic [1:0] REQ_TICK       = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CHANNELS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE       = 2'd3;

   // configuration reset values
   localparam logic [STEP_W-1:0]  STEP_RESET      = STEP_W'(100);
   localparam logic [ACT_W-1:0]   ACTIVE_RESET    = ACT_W'(8);
   localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = PULSE_W'(544);
   localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = PULSE_W'(2400);

   // target value that means no target
   localparam logic [TGT_W-1:0] NO_TARGET = {TGT_W{1'b1}};

   // control and status between sequencer and divider
   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic [PULSE_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: src/mcssl_div.sv
// reciprocal-multiply divider by the full-scale constant: the scaled dividend is registered, then the quotient
module mcssl_div
   import mcssl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   // full scale is 16 times 1125: drop four bits, then scale by 2^34 / 1125 rounded up
   // exact for every dividend below full scale times 4096
   localparam int PRE_SHIFT = 4;
   localparam int SCALED_W  = PROD_W - PRE_SHIFT;
   localparam int RECIP_W   = 24;
   localparam int RECIP_SH  = 34;
   localparam int MUL_W     = SCALED_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(15270995);

   logic [SCALED_W-1:0] scaled_ff, scaled_in;
   logic [PULSE_W-1:0]  q_ff, q_in;
   logic                busy_ff, busy_in;
   logic [MUL_W-1:0]    recip_prod;

   // load the scaled dividend, then one reciprocal multiply
   always_comb begin
      scaled_in  = scaled_ff;
      q_in       = q_ff;
      busy_in    = 1'b0;
      recip_prod = {{RECIP_W{1'b0}}, scaled_ff} * {{SCALED_W{1'b0}}, RECIP};
      if (div_req.start) begin
         scaled_in = div_req.dividend[PROD_W-1:PRE_SHIFT];
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         q_in = recip_prod[RECIP_SH +: PULSE_W];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      q_ff      <= q_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = q_ff;

endmodule

FILE: src/multi_channel_servo_slew_limiter.sv
// servo slew limiter top level: channel state, request sequencer and result register
// set, add and direct requests take effect at their transfer and give no result.
// a tick visits each active channel in turn: move, multiply, divider start,
// reciprocal multiply, quotient handover, emit (the emit waits out result stalls).
// the input is stalled for the whole tick.
// synchronous reset sets positions to zero, targets to none, registers to defaults.
module multi_channel_servo_slew_limiter
   import mcssl_pkg::*;
#(
   parameter int MAX_CHANNELS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [CH_FLD_W-1:0]   req_channel,
   input  logic signed [TGT_W-1:0] req_command_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CH_FLD_W-1:0]   rsp_out_channel,
   output logic [PULSE_W-1:0]    rsp_pulse_us,
   output logic [POS_W-1:0]      rsp_position,
   output logic                  rsp_moving,
   output logic                  rsp_last,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int NUM_USED = (MAX_CHANNELS < RESULT_CAP) ? MAX_CHANNELS : RESULT_CAP;
   localparam int CH_W     = (NUM_USED > 1) ? $clog2(NUM_USED) : 1;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MOVE  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DIVS  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CH_W-1:0]    cnt_ff, cnt_in;
   logic [ACT_W-1:0]   n_ff, n_in;

   logic [STEP_W-1:0]  step_ff;
   logic [ACT_W-1:0]   active_ff;
   logic [PULSE_W-1:0] min_pulse_ff;
   logic [PULSE_W-1:0] max_pulse_ff;

   logic [POS_W-1:0]   pos_mem_ff [NUM_USED];
   logic [TGT_W-1:0]   tgt_mem_ff [NUM_USED];

   logic [POS_W-1:0]   cur_pos_ff, cur_pos_in;
   logic               moving_ff, moving_in;
   logic [PROD_W-1:0]  prod_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CH_FLD_W-1:0] rsp_ch_ff;
   logic [PULSE_W-1:0] rsp_pulse_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic               rsp_moving_ff;
   logic               rsp_last_ff;
   logic               load_rsp;

   logic               req_xfer;
   logic               rsp_xfer;
   logic [CH_W-1:0]    req_idx;
   logic [CH_W-1:0]    rd_idx;
   logic [POS_W-1:0]   rd_pos;
   logic [TGT_W-1:0]   rd_tgt;
   logic               ch_ok;
   logic               pos_we, tgt_we;
   logic [POS_W-1:0]   pos_wdata;
   logic [TGT_W-1:0]   tgt_wdata;
   logic signed [TGT_W:0] add_sum;
   logic               direct_ok;
   logic               tgt_ok;
   logic signed [TGT_W:0] up_diff, down_diff;
   logic [POS_W:0]     pos_up, pos_down;
   logic [PULSE_W-1:0] span_mag;
   logic               span_neg;
   logic [ACT_W-1:0]   n_sat;
   logic               is_last;
   logic [PULSE_W-1:0] pulse_val;

   div_req_type div_req;
   div_rsp_type div_rsp;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // channel state read port, shared by requests and the tick walk
   assign req_idx = req_channel[CH_W-1:0];
   assign rd_idx  = (state_ff == S_IDLE) ? req_idx : cnt_ff;
   assign rd_pos  = pos_mem_ff[rd_idx];
   assign rd_tgt  = tgt_mem_ff[rd_idx];
   assign ch_ok   = {1'b0, req_channel} < (CH_FLD_W+1)'(NUM_USED);

   // request arithmetic
   assign add_sum   = $signed({rd_tgt[TGT_W-1], rd_tgt})
                    + $signed({req_command_value[TGT_W-1], req_command_value});
   assign direct_ok = !req_command_value[TGT_W-1]
                    && (req_command_value[TGT_W-2:0] <= FULL_SCALE);

   // slew step toward the target
   assign tgt_ok    = !rd_tgt[TGT_W-1] && (rd_tgt[TGT_W-2:0] <= FULL_SCALE);
   assign up_diff   = $signed({2'b00, rd_tgt[TGT_W-2:0]}) - $signed({2'b00, rd_pos});
   assign down_diff = $signed({2'b00, rd_pos}) - $signed({2'b00, rd_tgt[TGT_W-2:0]});
   assign pos_up    = {1'b0, rd_pos} + {1'b0, step_ff};
   assign pos_down  = {1'b0, rd_pos} - {1'b0, step_ff};

   // pulse span magnitude and direction
   assign span_neg = max_pulse_ff < min_pulse_ff;
   assign span_mag = span_neg ? (min_pulse_ff - max_pulse_ff) : (max_pulse_ff - min_pulse_ff);

   // active count saturated to the channels held
   assign n_sat   = (active_ff > ACT_W'(NUM_USED)) ? ACT_W'(NUM_USED) : active_ff;
   assign is_last = (ACT_W'(cnt_ff) + ACT_W'(1)) == n_ff;

   assign pulse_val = span_neg ? (min_pulse_ff - div_rsp.quotient)
                               : (min_pulse_ff + div_rsp.quotient);

   assign div_req.start    = (state_ff == S_DIVS);
   assign div_req.dividend = prod_ff;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      cur_pos_in = cur_pos_ff;
      moving_in  = moving_ff;
      pos_we     = 1'b0;
      tgt_we     = 1'b0;
      pos_wdata  = rd_pos;
      tgt_wdata  = rd_tgt;
      load_rsp   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_type)
                  REQ_SET_TARGET: begin
                     tgt_we    = ch_ok;
                     tgt_wdata = req_command_value;
                  end
                  REQ_ADD_TARGET: begin
                     tgt_we = ch_ok;
                     if (add_sum < 0) begin
                        tgt_wdata = '0;
                     end else if (add_sum > $signed((TGT_W+1)'(FULL_SCALE))) begin
                        tgt_wdata = TGT_W'(FULL_SCALE);
                     end else begin
                        tgt_wdata = add_sum[TGT_W-1:0];
                     end
                  end
                  REQ_DIRECT_POS: begin
                     pos_we    = ch_ok && direct_ok;
                     pos_wdata = req_command_value[POS_W-1:0];
                  end
                  default: begin
                     n_in   = n_sat;
                     cnt_in = '0;
                     if (n_sat != '0) begin
                        state_in = S_MOVE;
                     end
                  end
               endcase
            end
         end
         S_MOVE: begin
            cur_pos_in = rd_pos;
            moving_in  = 1'b0;
            if (tgt_ok) begin
               if (up_diff > $signed({2'b00, step_ff})) begin
                  moving_in = 1'b1;
                  if (pos_up <= (POS_W+1)'(FULL_SCALE)) begin
                     cur_pos_in = pos_up[POS_W-1:0];
                  end
               end else if (down_diff > $signed({2'b00, step_ff})) begin
                  moving_in = 1'b1;
                  if (!pos_down[POS_W]) begin
                     cur_pos_in = pos_down[POS_W-1:0];
                  end
               end
               pos_we    = 1'b1;
               pos_wdata = cur_pos_in;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_DIVS;
         end
         S_DIVS: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!div_rsp.busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + CH_W'(1);
                  state_in = S_MOVE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_RESET;
         active_ff    <= ACTIVE_RESET;
         min_pulse_ff <= MIN_PULSE_RESET;
         max_pulse_ff <= MAX_PULSE_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STEP_SIZE:       step_ff      <= csr_write_data[STEP_W-1:0];
               CSR_ACTIVE_CHANNELS: active_ff    <= csr_write_data[ACT_W-1:0];
               CSR_MIN_PULSE:       min_pulse_ff <= csr_write_data[PULSE_W-1:0];
               CSR_MAX_PULSE:       max_pulse_ff <= csr_write_data[PULSE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // per-channel position and target, written at one address a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_USED; i++) begin
            pos_mem_ff[i] <= '0;
            tgt_mem_ff[i] <= NO_TARGET;
         end
      end else begin
         if (pos_we) begin
            pos_mem_ff[rd_idx] <= pos_wdata;
         end
         if (tgt_we) begin
            tgt_mem_ff[rd_idx] <= tgt_wdata;
         end
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      cur_pos_ff <= cur_pos_in;
      moving_ff  <= moving_in;
      if (state_ff == S_MUL) begin
         prod_ff <= {{PULSE_W{1'b0}}, cur_pos_ff} * {{POS_W{1'b0}}, span_mag};
      end
      if (load_rsp) begin
         rsp_ch_ff     <= CH_FLD_W'(cnt_ff);
         rsp_pulse_ff  <= pulse_val;
         rsp_pos_ff    <= cur_pos_ff;
         rsp_moving_ff <= moving_ff;
         rsp_last_ff   <= is_last;
      end
   end

   // shared divider for the pulse mapping
   mcssl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_pulse_us    = rsp_pulse_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_moving      = rsp_moving_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: sim/mcssl_checker.sv
// checker for the servo slew limiter: follows every channel, predicts tick results, compares
module mcssl_checker
   import mcssl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [1:0]              req_type,
   input  logic [CH_FLD_W-1:0]     req_channel,
   input  logic signed [TGT_W-1:0] req_command_value,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [CH_FLD_W-1:0]     rsp_out_channel,
   input  logic [PULSE_W-1:0]      rsp_pulse_us,
   input  logic [POS_W-1:0]        rsp_position,
   input  logic                    rsp_moving,
   input  logic                    rsp_last,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   output int                      mismatch_count,
   output int                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS = 8;
   localparam int TRAVEL   = 18000;

   typedef struct packed {
      logic [CH_FLD_W-1:0] chan;
      logic [PULSE_W-1:0]  pulse;
      logic [POS_W-1:0]    pos;
      logic                moving;
      logic                last;
   } servo_result_type;

   // predicted settings and channel state
   logic [STEP_W-1:0]       step_reg;
   logic [ACT_W-1:0]        active_reg;
   logic [PULSE_W-1:0]      min_pulse_reg;
   logic [PULSE_W-1:0]      max_pulse_reg;
   logic [POS_W-1:0]        servo_pos [CHANNELS];
   logic signed [TGT_W-1:0] servo_target [CHANNELS];

   // tick results still owed by the block, oldest first
   servo_result_type owed_results [$];
   int               fails = 0;

   // linear map from position to pulse width, quotient truncated towards zero
   function automatic logic [PULSE_W-1:0] pulse_at(input int pos);
      int span;
      span = int'(max_pulse_reg) - int'(min_pulse_reg);
      return PULSE_W'(int'(min_pulse_reg) + (pos * span) / TRAVEL);
   endfunction

   task automatic note_failure(input string what);
      fails++;
      if (fails <= 10)
         $display("[%0t] %s", $realtime, what);
   endtask

   // apply one accepted request to the predicted state, queueing any tick results
   task automatic apply_request(input logic [1:0] kind, input logic [CH_FLD_W-1:0] ch,
                                input logic signed [TGT_W-1:0] val);
      int               sum;
      int               n;
      int               pos;
      int               tgt;
      int               step;
      int               next_pos;
      logic             moving;
      servo_result_type r;
      step = int'(step_reg);
      case (kind)
         REQ_SET_TARGET: servo_target[ch] = val;
         REQ_ADD_TARGET: begin
            sum = int'(servo_target[ch]) + int'(val);
            if (sum < 0)
               sum = 0;
            if (sum > TRAVEL)
               sum = TRAVEL;
            servo_target[ch] = TGT_W'(sum);
         end
         REQ_DIRECT_POS: begin
            if (val >= 0 && val <= TRAVEL)
               servo_pos[ch] = POS_W'(val);
         end
         REQ_TICK: begin
            n = (active_reg > CHANNELS) ? CHANNELS : int'(active_reg);
            for (int i = 0; i < n; i++) begin
               pos    = int'(servo_pos[i]);
               tgt    = int'(servo_target[i]);
               moving = 1'b0;
               // only a target inside the travel range pulls the channel
               if (tgt >= 0 && tgt <= TRAVEL) begin
                  next_pos = pos;
                  if (pos - tgt < -step) begin
                     moving   = 1'b1;
                     next_pos = pos + step;
                  end else if (pos - tgt > step) begin
                     moving   = 1'b1;
                     next_pos = pos - step;
                  end
                  if (next_pos >= 0 && next_pos <= TRAVEL)
                     pos = next_pos;
                  servo_pos[i] = POS_W'(pos);
               end
               r.chan   = CH_FLD_W'(i);
               r.pulse  = pulse_at(pos);
               r.pos    = POS_W'(pos);
               r.moving = moving;
               r.last   = (i == n - 1);
               owed_results.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      servo_result_type got;
      servo_result_type want;
      if (reset) begin
         step_reg      = STEP_RESET;
         active_reg    = ACTIVE_RESET;
         min_pulse_reg = MIN_PULSE_RESET;
         max_pulse_reg = MAX_PULSE_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            servo_pos[i]    = '0;
            servo_target[i] = NO_TARGET;
         end
         owed_results.delete();
      end else begin
         // result transfer against the oldest owed result
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_channel, rsp_pulse_us, rsp_position, rsp_moving, rsp_last};
            if (owed_results.size() == 0) begin
               note_failure($sformatf("unexpected result: ch %0d pulse %0d pos %0d mov %0b last %0b",
                  got.chan, got.pulse, got.pos, got.moving, got.last));
            end else begin
               want = owed_results.pop_front();
               if (got.chan !== want.chan || got.pulse !== want.pulse || got.pos !== want.pos ||
                   got.moving !== want.moving || got.last !== want.last)
                  note_failure($sformatf({"result mismatch: expected ch %0d pulse %0d pos %0d ",
                     "mov %0b last %0b, got ch %0d pulse %0d pos %0d mov %0b last %0b"},
                     want.chan, want.pulse, want.pos, want.moving, want.last,
                     got.chan, got.pulse, got.pos, got.moving, got.last));
            end
         end
         // request transfer
         if (req_valid && !req_stall)
            apply_request(req_type, req_channel, req_command_value);
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STEP_SIZE:       step_reg      = csr_write_data[STEP_W-1:0];
               CSR_ACTIVE_CHANNELS: active_reg    = csr_write_data[ACT_W-1:0];
               CSR_MIN_PULSE:       min_pulse_reg = csr_write_data[PULSE_W-1:0];
               CSR_MAX_PULSE:       max_pulse_reg = csr_write_data[PULSE_W-1:0];
               default: ;
            endcase
         end
      end
      mismatch_count <= fails;
      pending_count  <= owed_results.size();
   end

endmodule

FILE: sim/tb_multi_channel_servo_slew_limiter.sv
// testbench top for the servo slew limiter: stimulus, stall patterns and verdict
module tb_multi_channel_servo_slew_limiter
   import mcssl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 150;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS     = 68;

   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_type          = REQ_TICK;
   logic [CH_FLD_W-1:0]     req_channel       = '0;
   logic signed [TGT_W-1:0] req_command_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall         = 1'b0;
   logic [CH_FLD_W-1:0]     rsp_out_channel;
   logic [PULSE_W-1:0]      rsp_pulse_us;
   logic [POS_W-1:0]        rsp_position;
   logic                    rsp_moving;
   logic                    rsp_last;
   logic                    csr_write_enable  = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index         = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data    = '0;

   int   mismatch_count;
   int   pending_count;
   int   send_idle_pct     = 25;
   int   recv_stall_pct    = 65;
   int   cycle_count       = 0;
   logic hold_off          = 1'b0;
   logic pressure_request  = 1'b0;

   multi_channel_servo_slew_limiter #(.MAX_CHANNELS(8)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_channel       (req_channel),
      .req_command_value (req_command_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_pulse_us      (rsp_pulse_us),
      .rsp_position      (rsp_position),
      .rsp_moving        (rsp_moving),
      .rsp_last          (rsp_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   mcssl_checker servo_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_channel       (req_channel),
      .req_command_value (req_command_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_pulse_us      (rsp_pulse_us),
      .rsp_position      (rsp_position),
      .rsp_moving        (rsp_moving),
      .rsp_last          (rsp_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side stalls at random, or for the whole hold-off
   initial begin
      forever begin
         @(posedge clock);
         rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // long hold-off on the result side, so the block backs up into its input
   initial begin
      wait (pressure_request);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("multi_channel_servo_slew_limiter test failed");
      $finish;
   end

   // one request transfer, with random idle cycles in front of it
   task automatic send_request(input logic [1:0] kind, input int ch, input int val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_channel       <= CH_FLD_W'(ch);
      req_command_value <= TGT_W'(val);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mostly in-range targets and positions with ticks between them, some raw noise
   task automatic send_random_request();
      int pick;
      int ch;
      int val;
      pick = $urandom_range(99);
      ch   = $urandom_range(7);
      if (pick < 35) begin
         send_request(REQ_TICK, ch, $urandom);
      end else if (pick < 60) begin
         val = ($urandom_range(9) == 0) ? $urandom : $urandom_range(18000);
         send_request(REQ_SET_TARGET, ch, val);
      end else if (pick < 78) begin
         val = ($urandom_range(9) == 0) ? $urandom : int'($urandom_range(6000)) - 3000;
         send_request(REQ_ADD_TARGET, ch, val);
      end else begin
         val = ($urandom_range(9) == 0) ? $urandom : $urandom_range(18000);
         send_request(REQ_DIRECT_POS, ch, val);
      end
   endtask

   // stop offering, wait for every owed result, then let a full tick run out
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers back to back
   task automatic write_settings(input int step, input int active, input int low_us,
                                 input int high_us);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_STEP_SIZE;
      csr_write_data   <= CSR_DATA_W'(step);
      @(posedge clock);
      csr_index        <= CSR_ACTIVE_CHANNELS;
      csr_write_data   <= CSR_DATA_W'(active);
      @(posedge clock);
      csr_index        <= CSR_MIN_PULSE;
      csr_write_data   <= CSR_DATA_W'(low_us);
      @(posedge clock);
      csr_index        <= CSR_MAX_PULSE;
      csr_write_data   <= CSR_DATA_W'(high_us);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_random_settings();
      int step;
      step = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1, 1500);
      write_settings(step, $urandom_range(15), $urandom_range(4095), $urandom_range(4095));
   endtask

   task automatic run_traffic(input int items);
      repeat (items) send_random_request();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, target and position corner cases
      send_request(REQ_TICK, 0, 0);
      send_request(REQ_SET_TARGET, 0, 18000);
      send_request(REQ_SET_TARGET, 1, 0);
      send_request(REQ_SET_TARGET, 2, -1);
      send_request(REQ_SET_TARGET, 3, 32767);
      send_request(REQ_SET_TARGET, 4, -32768);
      send_request(REQ_ADD_TARGET, 5, 32767);
      send_request(REQ_ADD_TARGET, 6, -32768);
      send_request(REQ_ADD_TARGET, 7, 150);
      send_request(REQ_DIRECT_POS, 0, 18000);
      send_request(REQ_DIRECT_POS, 1, -1);
      send_request(REQ_DIRECT_POS, 2, 18001);
      send_request(REQ_DIRECT_POS, 7, -32768);
      send_request(REQ_DIRECT_POS, 4, 12345);
      send_request(REQ_TICK, 7, -1);
      send_request(REQ_TICK, 3, 0);

      // zero step still reports motion, falling pulse map
      quiesce();
      write_settings(0, 1, 4095, 0);
      send_request(REQ_SET_TARGET, 0, 0);
      send_request(REQ_TICK, 0, 0);

      // no active channels: the tick gives nothing
      quiesce();
      write_settings(18000, 0, 0, 4095);
      send_request(REQ_TICK, 0, 0);
      send_request(REQ_DIRECT_POS, 3, 9000);

      // channel count above eight saturates, all-ones step
      quiesce();
      write_settings(32767, 15, 4095, 4095);
      send_request(REQ_TICK, 5, 0);

      // random traffic, sender idling lightly and receiver heavily
      quiesce();
      write_settings($urandom_range(50, 2000), 8, 544, 2400);
      run_traffic(PHASE_ITEMS);
      quiesce();
      write_random_settings();
      run_traffic(PHASE_ITEMS);

      // the other way round
      send_idle_pct  = 65;
      recv_stall_pct = 25;
      quiesce();
      write_settings(1, 8, 0, 4095);
      run_traffic(PHASE_ITEMS);
      quiesce();
      write_random_settings();
      run_traffic(PHASE_ITEMS);

      // no idling, with one long hold-off on the result side
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      quiesce();
      write_settings(500, 8, 1000, 2000);
      pressure_request = 1'b1;
      run_traffic(PHASE_ITEMS);
      quiesce();
      write_random_settings();
      run_traffic(PHASE_ITEMS);

      quiesce();
      if (mismatch_count == 0)
         $display("multi_channel_servo_slew_limiter test passed");
      else
         $display("multi_channel_servo_slew_limiter test failed");
      $finish;
   end

endmodule
